@@ rtl/core/nec_ir_pkg.sv @@
// Shared types and constants for the NEC infrared edge decoder.
`default_nettype none

package nec_ir_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_ABORT_LIMIT = 2'd0;
  localparam logic [1:0] CFG_START_GAP   = 2'd1;
  localparam logic [1:0] CFG_ZERO_BIT    = 2'd2;
  localparam logic [1:0] CFG_ONE_BIT     = 2'd3;

  localparam logic [7:0] ABORT_LIMIT_RST = 8'd50;
  localparam logic [7:0] START_GAP_RST   = 8'd13;
  localparam logic [7:0] ZERO_BIT_RST    = 8'd1;
  localparam logic [7:0] ONE_BIT_RST     = 8'd2;

  // ms = floor(diff * 0.122); any diff at or above MS_SAT_DIFF gives more than 255 ms.
  // Below that, (diff * MS_RECIP) >> MS_SHIFT is exact: the excess stays under
  // 0.0015 ms while the fraction never comes closer than 0.002 to the next integer.
  localparam int unsigned  MS_SHIFT    = 20;
  localparam int unsigned  DIFF_BITS   = 12;
  localparam int unsigned  RECIP_BITS  = 17;
  localparam logic [15:0]  MS_SAT_DIFF = 16'd2099;
  localparam logic [16:0]  MS_RECIP    = 17'd127927;
  localparam logic [7:0]   MS_MAX      = 8'hFF;

  localparam logic [2:0]   BIT_LAST    = 3'd7;
  localparam logic [1:0]   SLOT_FIRST  = 2'd3;
  localparam logic [1:0]   SLOT_LAST   = 2'd0;

  typedef struct packed {
    logic [7:0] abort_limit_ms;
    logic [7:0] start_gap_ms;
    logic [7:0] zero_bit_ms;
    logic [7:0] one_bit_ms;
  } cfg_t;

  typedef struct packed {
    logic       frame_done;
    logic [7:0] command_byte;
    logic       frame_valid;
    logic       clear_timer;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/nec_ir_interval.sv @@
// Edge interval to whole milliseconds, saturated at 255.
`default_nettype none

module nec_ir_interval (
  input  wire logic [15:0] now_stamp,
  input  wire logic [15:0] last_stamp,
  output logic      [7:0]  interval_ms
);

  localparam int unsigned ProdBits = nec_ir_pkg::DIFF_BITS + nec_ir_pkg::RECIP_BITS;

  logic [15:0]         diff;
  logic                sat;
  logic [ProdBits-1:0] prod;

  // modulo 2^16 difference covers counter wrap
  assign diff = now_stamp - last_stamp;
  assign sat  = (diff >= nec_ir_pkg::MS_SAT_DIFF);
  assign prod = ProdBits'(diff[nec_ir_pkg::DIFF_BITS-1:0]) * ProdBits'(nec_ir_pkg::MS_RECIP);

  assign interval_ms = sat ? nec_ir_pkg::MS_MAX
                           : prod[nec_ir_pkg::MS_SHIFT +: 8];

endmodule

`default_nettype wire

@@ rtl/core/nec_ir_frame.sv @@
// Frame state: last stamp, bit and byte counters, frame word and result decode.
`default_nettype none

module nec_ir_frame (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nec_ir_pkg::cfg_t    cfg,
  input  wire logic                step,
  input  wire logic [15:0]         stamp,
  output nec_ir_pkg::result_t      res
);

  logic [15:0] last_stamp_r, last_stamp_nxt;
  logic [31:0] frame_bits_r, frame_bits_nxt;
  logic [2:0]  bit_in_byte_r, bit_in_byte_nxt;
  logic [1:0]  byte_slot_r, byte_slot_nxt;

  logic [7:0]  ms;
  logic        first_edge;
  logic        abort;
  logic        is_zero;
  logic        is_one;
  logic        hit;
  logic        done;
  logic [4:0]  pos;
  logic [7:0]  addr, addr_inv, cmd, cmd_inv;

  nec_ir_interval u_interval (
    .now_stamp   (stamp),
    .last_stamp  (last_stamp_r),
    .interval_ms (ms)
  );

  assign first_edge = (last_stamp_r == 16'd0);
  assign abort      = !first_edge &&
                      ((ms >= cfg.abort_limit_ms) || (ms == cfg.start_gap_ms));
  assign is_zero    = (ms == cfg.zero_bit_ms);
  assign is_one     = (ms == cfg.one_bit_ms);
  assign hit        = !first_edge && !abort && (is_zero || is_one);
  assign pos        = {byte_slot_r, bit_in_byte_r};
  assign done       = hit && (bit_in_byte_r == nec_ir_pkg::BIT_LAST) &&
                      (byte_slot_r == nec_ir_pkg::SLOT_LAST);

  always_comb begin
    frame_bits_nxt  = frame_bits_r;
    bit_in_byte_nxt = bit_in_byte_r;
    byte_slot_nxt   = byte_slot_r;
    last_stamp_nxt  = stamp;
    if (abort || done) begin
      bit_in_byte_nxt = 3'd0;
      byte_slot_nxt   = nec_ir_pkg::SLOT_FIRST;
      last_stamp_nxt  = 16'd0;
    end else if (hit) begin
      if (bit_in_byte_r == nec_ir_pkg::BIT_LAST) begin
        bit_in_byte_nxt = 3'd0;
        byte_slot_nxt   = byte_slot_r - 2'd1;
      end else begin
        bit_in_byte_nxt = bit_in_byte_r + 3'd1;
      end
    end
    // zero interval wins when both bit intervals match
    if (hit) begin
      frame_bits_nxt[pos] = !is_zero;
    end
  end

  assign addr     = frame_bits_nxt[31:24];
  assign addr_inv = frame_bits_nxt[23:16];
  assign cmd      = frame_bits_nxt[15:8];
  assign cmd_inv  = frame_bits_nxt[7:0];

  always_comb begin
    res.frame_done   = done;
    res.command_byte = done ? cmd : 8'd0;
    res.frame_valid  = done && ((addr & addr_inv) == 8'd0) && ((cmd & cmd_inv) == 8'd0);
    res.clear_timer  = abort;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_stamp_r  <= 16'd0;
      bit_in_byte_r <= 3'd0;
      byte_slot_r   <= nec_ir_pkg::SLOT_FIRST;
    end else if (step) begin
      last_stamp_r  <= last_stamp_nxt;
      bit_in_byte_r <= bit_in_byte_nxt;
      byte_slot_r   <= byte_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      frame_bits_r <= frame_bits_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nec_ir_edge_decoder.sv @@
// NEC infrared edge decoder: one result per falling-edge timestamp.
//
// Input channel: in_valid / in_stall with in_edge_stamp, the 8192 Hz counter
// value captured at each falling edge of the IR receiver output.
// Result channel: out_valid / out_stall with out_frame_done, out_command_byte,
// out_frame_valid and out_clear_timer. Every accepted stamp yields one result.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (abort limit, start gap, zero bit, one bit, all in ms); write only while idle.
// Each stamp passes through the input register, then the decode and result
// register. Throughput: one stamp per cycle while the result side does not
// stall, set by the single-step update of the frame state between them.
// Reset (rst_n low, synchronous) empties both registers, restores the default
// timings and returns the decoder to waiting for a first edge.
// A stalled result holds; one further stamp waits in the input register, after
// which in_stall rises until the result is taken.
`default_nettype none

module nec_ir_edge_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] in_edge_stamp,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_frame_done,
  output logic      [7:0]  out_command_byte,
  output logic             out_frame_valid,
  output logic             out_clear_timer,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata
);

  nec_ir_pkg::cfg_t    cfg_r;
  nec_ir_pkg::result_t res;
  nec_ir_pkg::result_t out_r;

  logic        in_v_r;
  logic [15:0] in_stamp_r;
  logic        out_v_r;
  logic        advance;

  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.abort_limit_ms <= nec_ir_pkg::ABORT_LIMIT_RST;
      cfg_r.start_gap_ms   <= nec_ir_pkg::START_GAP_RST;
      cfg_r.zero_bit_ms    <= nec_ir_pkg::ZERO_BIT_RST;
      cfg_r.one_bit_ms     <= nec_ir_pkg::ONE_BIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        nec_ir_pkg::CFG_ABORT_LIMIT: cfg_r.abort_limit_ms <= cfg_wdata;
        nec_ir_pkg::CFG_START_GAP:   cfg_r.start_gap_ms   <= cfg_wdata;
        nec_ir_pkg::CFG_ZERO_BIT:    cfg_r.zero_bit_ms    <= cfg_wdata;
        nec_ir_pkg::CFG_ONE_BIT:     cfg_r.one_bit_ms     <= cfg_wdata;
        default:                     cfg_r <= cfg_r;
      endcase
    end
  end

  // input register: take a transfer whenever it is empty or draining
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_stamp_r <= in_edge_stamp;
    end
  end

  nec_ir_frame u_frame (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .step  (advance),
    .stamp (in_stamp_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_valid        = out_v_r;
  assign out_frame_done   = out_r.frame_done;
  assign out_command_byte = out_r.command_byte;
  assign out_frame_valid  = out_r.frame_valid;
  assign out_clear_timer  = out_r.clear_timer;

endmodule

`default_nettype wire

@@ verif/nec_ir_edge_decoder_checker.sv @@
// Checker for the NEC infrared edge decoder: predicts every result and compares.
`timescale 1ns / 1ps

module nec_ir_edge_decoder_checker
  import nec_ir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [15:0] in_edge_stamp,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_frame_done,
  input  wire logic [7:0]  out_command_byte,
  input  wire logic        out_frame_valid,
  input  wire logic        out_clear_timer,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_wdata,
  output int               fail_count,
  output int               pending
);

  // Timing registers as last written
  logic [7:0]  abort_ms;
  logic [7:0]  start_ms;
  logic [7:0]  zero_ms;
  logic [7:0]  one_ms;

  // Decoder state
  logic [15:0] held_stamp;
  logic [31:0] frame_word;
  logic [2:0]  bit_q;
  logic [1:0]  slot_q;

  result_t     frame_results_q [$];
  result_t     want;

  function automatic logic [7:0] gap_ms(input logic [15:0] gap);
    int unsigned scaled;
    scaled = (32'(gap) * 32'd122) / 32'd1000;
    return (scaled > 255) ? MS_MAX : scaled[7:0];
  endfunction

  function automatic result_t decode_edge(input logic [15:0] stamp);
    result_t    res;
    logic [7:0] ms;
    logic [4:0] pos;
    res = '0;
    if (held_stamp == 16'd0) begin
      held_stamp = stamp;
      return res;
    end
    ms = gap_ms(stamp - held_stamp);
    held_stamp = stamp;
    if (ms >= abort_ms || ms == start_ms) begin
      bit_q = 3'd0;
      slot_q = SLOT_FIRST;
      held_stamp = 16'd0;
      res.clear_timer = 1'b1;
      return res;
    end
    if (ms != zero_ms && ms != one_ms) return res;
    // zero interval wins when both bit timings are equal
    pos = {slot_q, bit_q};
    frame_word[pos] = (ms != zero_ms);
    if (bit_q == BIT_LAST) begin
      bit_q = 3'd0;
      if (slot_q == SLOT_LAST) begin
        res.frame_done = 1'b1;
        res.command_byte = frame_word[15:8];
        res.frame_valid = ((frame_word[31:24] & frame_word[23:16]) == 8'd0) &&
                          ((frame_word[15:8] & frame_word[7:0]) == 8'd0);
        slot_q = SLOT_FIRST;
        held_stamp = 16'd0;
      end else begin
        slot_q = slot_q - 2'd1;
      end
    end else begin
      bit_q = bit_q + 3'd1;
    end
    return res;
  endfunction

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] act_v);
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      abort_ms = ABORT_LIMIT_RST;
      start_ms = START_GAP_RST;
      zero_ms = ZERO_BIT_RST;
      one_ms = ONE_BIT_RST;
      held_stamp = 16'd0;
      frame_word = 32'd0;
      bit_q = 3'd0;
      slot_q = SLOT_FIRST;
      frame_results_q.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ABORT_LIMIT: abort_ms = cfg_wdata;
          CFG_START_GAP:   start_ms = cfg_wdata;
          CFG_ZERO_BIT:    zero_ms = cfg_wdata;
          CFG_ONE_BIT:     one_ms = cfg_wdata;
          default: ;
        endcase
      end
      // retire the oldest expectation before queuing this edge's result
      if (out_valid && !out_stall) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: result transfer, expected none, got %0h %0h %0h %0h", $time,
                   out_frame_done, out_command_byte, out_frame_valid, out_clear_timer);
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (out_frame_done !== want.frame_done)
            report_field("frame_done", 8'(want.frame_done), 8'(out_frame_done));
          if (out_command_byte !== want.command_byte)
            report_field("command_byte", want.command_byte, out_command_byte);
          if (out_frame_valid !== want.frame_valid)
            report_field("frame_valid", 8'(want.frame_valid), 8'(out_frame_valid));
          if (out_clear_timer !== want.clear_timer)
            report_field("clear_timer", 8'(want.clear_timer), 8'(out_clear_timer));
        end
      end
      if (in_valid && !in_stall)
        frame_results_q.push_back(decode_edge(in_edge_stamp));
      pending <= frame_results_q.size();
    end
  end

endmodule

@@ verif/nec_ir_edge_decoder_tb.sv @@
// Testbench top for the NEC infrared edge decoder: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module nec_ir_edge_decoder_tb;
  import nec_ir_pkg::*;

  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 120;
  localparam int SETTLE_CYCLES = 8;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_edge_stamp;
  logic        out_valid;
  logic        out_stall;
  logic        out_frame_done;
  logic [7:0]  out_command_byte;
  logic        out_frame_valid;
  logic        out_clear_timer;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;

  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          sent_total = 0;
  bit          idle_on = 1'b1;
  bit          pressure_req = 1'b0;
  logic [15:0] cur_stamp = 16'd0;
  cfg_t        cur_cfg;
  cfg_t        phase_cfg [5];

  nec_ir_edge_decoder dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_edge_stamp    (in_edge_stamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_done   (out_frame_done),
    .out_command_byte (out_command_byte),
    .out_frame_valid  (out_frame_valid),
    .out_clear_timer  (out_clear_timer),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  nec_ir_edge_decoder_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_edge_stamp    (in_edge_stamp),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_done   (out_frame_done),
    .out_command_byte (out_command_byte),
    .out_frame_valid  (out_frame_valid),
    .out_clear_timer  (out_clear_timer),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Random counter difference that converts to exactly m milliseconds
  function automatic logic [15:0] gap_for_ms(input logic [7:0] m);
    int unsigned mi, lo, hi;
    mi = m;
    lo = (1000 * mi + 121) / 122;
    hi = (m == MS_MAX) ? 65535 : (1000 * (mi + 1) + 121) / 122 - 1;
    return 16'($urandom_range(hi, lo));
  endfunction

  // An interval the decoder ignores under the current timings, if any
  function automatic logic [7:0] spare_ms();
    int         base;
    logic [7:0] m;
    base = $urandom_range(255);
    for (int k = 0; k < 256; k++) begin
      m = 8'(base + k);
      if (m < cur_cfg.abort_limit_ms && m != cur_cfg.start_gap_ms &&
          m != cur_cfg.zero_bit_ms && m != cur_cfg.one_bit_ms)
        return m;
    end
    return cur_cfg.zero_bit_ms;
  endfunction

  task automatic send_stamp(input logic [15:0] v);
    while (idle_on && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_edge_stamp <= v;
    do begin
      @(posedge clk);
    end while (in_stall);
    sent_total++;
  endtask

  task automatic send_gap(input logic [7:0] m);
    cur_stamp = cur_stamp + gap_for_ms(m);
    send_stamp(cur_stamp);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    // the checker count is registered, so it lags behind the last transfer
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_timings(input cfg_t c);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= CFG_ABORT_LIMIT;
    cfg_wdata <= c.abort_limit_ms;
    @(posedge clk);
    cfg_index <= CFG_START_GAP;
    cfg_wdata <= c.start_gap_ms;
    @(posedge clk);
    cfg_index <= CFG_ZERO_BIT;
    cfg_wdata <= c.zero_bit_ms;
    @(posedge clk);
    cfg_index <= CFG_ONE_BIT;
    cfg_wdata <= c.one_bit_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  task automatic send_frame(input bit broken);
    logic [31:0] word;
    logic [7:0]  addr, cmd;
    int          cut;
    bit          truncate;
    addr = 8'($urandom);
    cmd = 8'($urandom);
    if ($urandom_range(1)) word = {addr, ~addr, cmd, ~cmd};
    else word = $urandom;
    cut = broken ? $urandom_range(31) : 32;
    truncate = $urandom_range(1);
    // leave the decoder holding a stamp, then restart it with the start gap
    send_gap(spare_ms());
    send_gap(cur_cfg.start_gap_ms);
    cur_stamp = 16'($urandom_range(400, 1));
    send_stamp(cur_stamp);
    for (int i = 0; i < 32; i++) begin
      if (i == cut) begin
        if (truncate) break;
        send_gap(8'($urandom_range(255)));
      end
      send_gap(word[(3 - i / 8) * 8 + i % 8] ? cur_cfg.one_bit_ms : cur_cfg.zero_bit_ms);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(5, 1);
    repeat (n) begin
      if ($urandom_range(1)) begin
        cur_stamp = 16'($urandom);
        send_stamp(cur_stamp);
      end else begin
        send_gap(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic run_phase(input int n_items);
    int first;
    first = sent_total;
    while (sent_total - first < n_items) begin
      if ($urandom_range(99) < 70) send_frame($urandom_range(99) < 25);
      else send_noise();
    end
  endtask

  task automatic run_directed();
    send_stamp(16'h0000);          // zero stamp keeps waiting for a first edge
    send_stamp(16'h0000);
    send_stamp(16'hFFFF);
    send_stamp(16'h0005);          // counter wrap, short ignored interval
    send_stamp(16'h0003);          // near-full wrap saturates and aborts
    cur_stamp = 16'h8000;
    send_stamp(cur_stamp);
    send_gap(cur_cfg.abort_limit_ms);
    cur_stamp = 16'h1234;
    send_stamp(cur_stamp);
    send_gap(cur_cfg.abort_limit_ms - 8'd1);
    send_gap(cur_cfg.start_gap_ms);
    cur_stamp = 16'h00FF;
    send_stamp(cur_stamp);
    send_gap(cur_cfg.start_gap_ms - 8'd1);
    send_gap(cur_cfg.start_gap_ms + 8'd1);
    send_gap(cur_cfg.zero_bit_ms);
    send_gap(cur_cfg.one_bit_ms);
    send_gap(cur_cfg.one_bit_ms);
    send_gap(8'd3);
    send_gap(8'd0);
    send_stamp(16'h0000);          // zero stamp after a held edge
    send_stamp(16'h0001);
    send_stamp(16'h0000);          // largest difference
    cur_stamp = 16'h0000;
  endtask

  // Result side: random stall, with one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold_left = 80;
        out_stall <= 1'b1;
      end else begin
        out_stall <= idle_on && ($urandom_range(99) < 21);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("nec_ir_edge_decoder_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_edge_stamp <= 16'd0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_ABORT_LIMIT;
    cfg_wdata <= 8'd0;
    cur_cfg = {ABORT_LIMIT_RST, START_GAP_RST, ZERO_BIT_RST, ONE_BIT_RST};
    phase_cfg[0] = {8'd255, 8'd0, 8'd3, 8'd7};
    phase_cfg[1] = {8'd1, 8'd255, 8'd0, 8'd0};
    phase_cfg[2] = {8'd255, 8'd100, 8'd254, 8'd0};
    phase_cfg[3] = {8'd20, 8'd9, 8'd4, 8'd4};
    phase_cfg[4] = {ABORT_LIMIT_RST, START_GAP_RST, ZERO_BIT_RST, ONE_BIT_RST};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_phase(PHASE_ITEMS);
    for (int p = 0; p < 5; p++) begin
      load_timings(phase_cfg[p]);
      if (p == 0) pressure_req = 1'b1;
      idle_on = (p != 3);
      run_phase(PHASE_ITEMS);
    end
    idle_on = 1'b1;
    drain();

    if (fail_count == 0 && pending == 0) begin
      $display("nec_ir_edge_decoder_tb OK");
    end else begin
      $display("nec_ir_edge_decoder_tb NOT OK");
    end
    $finish;
  end

endmodule
